// File: sv/sap_pkg.sv
`timescale 1ns / 1ps

package sap_pkg;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int DEG_W   = 9;
    localparam int JOG_W   = 2;
    localparam int COIL_W  = 4;
    localparam int ANG_W   = 19;
    localparam int STEP_W  = 17;
    localparam int TICKS_W = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 17;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_GOTO    = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd2;
    localparam logic [OP_W-1:0] OP_ZERO    = 3'd3;
    localparam logic [OP_W-1:0] OP_JOG     = 3'd4;

    // Jog directions
    localparam logic [JOG_W-1:0] JOG_STOP = 2'd0;
    localparam logic [JOG_W-1:0] JOG_CW   = 2'd1;
    localparam logic [JOG_W-1:0] JOG_CCW  = 2'd2;

    // Motion modes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POSITION = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JOG      = 2'd2;

    // Configuration register indexes
    localparam logic REG_STEP_SIZE   = 1'b0;
    localparam logic REG_PHASE_TICKS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]  STEP_SIZE_RST   = 17'd666;
    localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = 16'd2;

    typedef logic [COIL_W-1:0] coil_t;

    // Full-step coil sequence; cw: 8,1,2,4  ccw: 1,8,4,2
    function automatic coil_t coil_lookup(input logic cw, input logic [1:0] idx);
        coil_t p;
        case ({cw, idx})
            3'b100:  p = 4'h8;
            3'b101:  p = 4'h1;
            3'b110:  p = 4'h2;
            3'b111:  p = 4'h4;
            3'b000:  p = 4'h1;
            3'b001:  p = 4'h8;
            3'b010:  p = 4'h4;
            3'b011:  p = 4'h2;
            default: p = 4'h0;
        endcase
        return p;
    endfunction

endpackage

// File: sv/stepper_angle_positioner_top.sv
`timescale 1ns / 1ps

// Full-step position controller for a four-coil stepper motor.
//
// Input stream (s_*): one command per transfer. s_tuser carries the operation
// (tick, go to angle, advance clockwise, zero angle, jog); s_tdata carries the
// angle in whole degrees and the jog direction. Ticks pace the coil sequence.
// Output stream (m_*): exactly one result per input transfer with the coil
// pattern, shaft angle in millidegrees, busy flag and the arrived pulse.
//
// The result of a transfer is presented on m_tvalid at
// the following clock edge. Throughput is one transfer per cycle; the state
// update is a single pass of short logic between the state registers and
// the output register, so s_tready stays high while m_tready is high.
// When the receiver stalls, the result is held in the output register and
// s_tready drops until it is taken.
//
// Configuration (cfg_*): plain write port, step_size at index 0 and
// phase_ticks at index 1, to be written while no results are outstanding.
// Reset (aresetn low, synchronous): angle 0, motion idle, coils off,
// step_size 666, phase_ticks 2, output stream empty.

module stepper_angle_positioner_top
    import sap_pkg::*;
#(
    parameter int PHASE_TIMER_BITS = 16,
    parameter int FULL_TURN        = 360000
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [8:0] angle_deg, [10:9] jog_direction
    input  logic [OP_W-1:0]  s_tuser,   // [2:0] operation

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // [3:0] coil_pattern, [22:4] current_angle,
                                        // [23] busy_res, [24] arrived

    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int TMR_W = PHASE_TIMER_BITS;
    localparam int CMP_W = (TMR_W > TICKS_W) ? TMR_W : TICKS_W;
    localparam int HALF_TURN = FULL_TURN / 2;
    localparam logic [ANG_W-1:0] TURN = ANG_W'(FULL_TURN);
    localparam logic [ANG_W-1:0] HALF = ANG_W'(HALF_TURN);
    localparam logic [STEP_W-1:0] STEP_MOD_RST = STEP_W'(666 % FULL_TURN);

    // Step size modulo a full turn, by conditional subtraction of shifted turns
    function automatic logic [STEP_W-1:0] reduce_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        r = s;
        for (int k = STEP_W - 1; k >= 0; k--) begin
            if ((longint'(FULL_TURN) << k) < (longint'(1) << STEP_W)) begin
                if (r >= STEP_W'(longint'(FULL_TURN) << k)) begin
                    r = r - STEP_W'(longint'(FULL_TURN) << k);
                end
            end
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [STEP_W-1:0]  step_eff_reg;   // step_size with zero read as one
    logic [STEP_W-1:0]  step_mod_reg;   // same, modulo a full turn
    logic [TICKS_W-1:0] ticks_eff_reg;  // phase_ticks with zero read as one
    logic [STEP_W-1:0]  cfg_step_eff;
    logic [STEP_W:0]    step_twice;

    assign cfg_step_eff = (cfg_wdata == '0) ? STEP_W'(1) : cfg_wdata;
    assign step_twice   = {step_eff_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_eff_reg  <= STEP_SIZE_RST;
            step_mod_reg  <= STEP_MOD_RST;
            ticks_eff_reg <= PHASE_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STEP_SIZE: begin
                    step_eff_reg <= cfg_step_eff;
                    step_mod_reg <= reduce_step(cfg_step_eff);
                end
                REG_PHASE_TICKS: begin
                    ticks_eff_reg <= (cfg_wdata[TICKS_W-1:0] == '0) ?
                                     TICKS_W'(1) : cfg_wdata[TICKS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // ---------------- input fields ----------------
    logic [OP_W-1:0]  op;
    logic [DEG_W-1:0] deg;
    logic [JOG_W-1:0] jog;
    logic             s_xfer;

    assign op     = s_tuser;
    assign deg    = s_tdata[DEG_W-1:0];
    assign jog    = s_tdata[DEG_W +: JOG_W];
    assign s_xfer = s_tvalid && s_tready;

    // ---------------- target angle: deg*1000 modulo a turn ----------------
    // Split deg into its top three bits and low six bits; each part has a
    // small table of pre-reduced millidegree values.
    logic [ANG_W-1:0] hi_tab [8];
    logic [ANG_W-1:0] lo_tab [64];

    for (genvar g = 0; g < 8; g++) begin : g_hi
        localparam longint HV = (longint'(g) * 64000) % FULL_TURN;
        assign hi_tab[g] = ANG_W'(HV);
    end
    for (genvar g = 0; g < 64; g++) begin : g_lo
        localparam longint LV = (longint'(g) * 1000) % FULL_TURN;
        assign lo_tab[g] = ANG_W'(LV);
    end

    logic [ANG_W:0]   target_sum;
    logic [ANG_W-1:0] target;
    logic [ANG_W-1:0] advance_dist;

    assign target_sum   = {1'b0, hi_tab[deg[8:6]]} + {1'b0, lo_tab[deg[5:0]]};
    assign target       = (target_sum >= {1'b0, TURN}) ?
                          ANG_W'(target_sum - {1'b0, TURN}) : ANG_W'(target_sum);
    assign advance_dist = ANG_W'(deg) * ANG_W'(1000);

    // ---------------- state ----------------
    logic [ANG_W-1:0]  shaft_reg,  shaft_next;
    logic [ANG_W-1:0]  rem_reg,    rem_next;
    logic              cw_reg,     cw_next;
    logic [MODE_W-1:0] mode_reg,   mode_next;
    logic [1:0]        phase_reg,  phase_next;
    logic [TMR_W-1:0]  timer_reg,  timer_next;
    coil_t             coil_reg,   coil_next;
    logic              arrived_next;

    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    // go-to distance and direction by the shorter way
    logic [ANG_W-1:0] goto_diff;
    logic [ANG_W-1:0] goto_dist;
    logic             goto_cw;

    always_comb begin
        if (shaft_reg > target) begin
            goto_diff = shaft_reg - target;
            goto_cw   = (goto_diff >= HALF);
        end else begin
            goto_diff = target - shaft_reg;
            goto_cw   = !(goto_diff > HALF);
        end
        if ((shaft_reg > target) ? goto_cw : !goto_cw) begin
            goto_dist = TURN - goto_diff;
        end else begin
            goto_dist = goto_diff;
        end
    end

    // one angle step with wrap
    logic [ANG_W:0]   cw_sum;
    logic [ANG_W-1:0] angle_stepped;

    assign cw_sum = {1'b0, shaft_reg} + (ANG_W + 1)'(step_mod_reg);

    always_comb begin
        if (cw_reg) begin
            angle_stepped = (cw_sum >= {1'b0, TURN}) ?
                            ANG_W'(cw_sum - {1'b0, TURN}) : ANG_W'(cw_sum);
        end else if (shaft_reg >= ANG_W'(step_mod_reg)) begin
            angle_stepped = shaft_reg - ANG_W'(step_mod_reg);
        end else begin
            angle_stepped = shaft_reg + (TURN - ANG_W'(step_mod_reg));
        end
    end

    // tick timing
    logic [TMR_W-1:0] timer_inc;
    logic             period_end;
    logic [ANG_W-1:0] rem_dec;

    assign timer_inc  = timer_reg + TMR_W'(1);
    assign period_end = (CMP_W'(timer_inc) >= CMP_W'(ticks_eff_reg)) || (timer_inc == '0);
    assign rem_dec    = rem_reg - ANG_W'(step_eff_reg);

    // start of a positioned move (go-to or advance)
    logic [ANG_W-1:0] move_dist;
    logic             move_cw;

    assign move_dist = (op == OP_GOTO) ? goto_dist : advance_dist;
    assign move_cw   = (op == OP_GOTO) ? goto_cw : 1'b1;

    always_comb begin
        shaft_next   = shaft_reg;
        rem_next     = rem_reg;
        cw_next      = cw_reg;
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        coil_next    = coil_reg;
        arrived_next = 1'b0;

        case (op)
            OP_TICK: begin
                if (mode_reg != MODE_IDLE) begin
                    if (timer_reg == '0) begin
                        coil_next = coil_lookup(cw_reg, phase_reg);
                    end
                    if (period_end) begin
                        timer_next = '0;
                        phase_next = phase_reg + 2'd1;
                        if (phase_reg == 2'd3) begin
                            shaft_next = angle_stepped;
                            if (mode_reg == MODE_POSITION) begin
                                rem_next = rem_dec;
                                if (rem_dec <= ANG_W'(step_twice)) begin
                                    mode_next    = MODE_IDLE;
                                    rem_next     = '0;
                                    arrived_next = 1'b1;
                                end
                            end
                        end
                    end else begin
                        timer_next = timer_inc;
                    end
                end
            end
            OP_GOTO, OP_ADVANCE: begin
                phase_next = '0;
                timer_next = '0;
                cw_next    = move_cw;
                if (move_dist <= ANG_W'(step_twice)) begin
                    mode_next    = MODE_IDLE;
                    rem_next     = '0;
                    arrived_next = 1'b1;
                end else begin
                    mode_next = MODE_POSITION;
                    rem_next  = move_dist;
                end
            end
            OP_ZERO: begin
                shaft_next = '0;
                rem_next   = '0;
                mode_next  = MODE_IDLE;
                phase_next = '0;
                timer_next = '0;
            end
            OP_JOG: begin
                phase_next = '0;
                timer_next = '0;
                rem_next   = '0;
                case (jog)
                    JOG_CW: begin
                        mode_next = MODE_JOG;
                        cw_next   = 1'b1;
                    end
                    JOG_CCW: begin
                        mode_next = MODE_JOG;
                        cw_next   = 1'b0;
                    end
                    default: mode_next = MODE_IDLE;
                endcase
            end
            default: ;  // unused codes leave the state alone
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shaft_reg <= '0;
            rem_reg   <= '0;
            cw_reg    <= 1'b0;
            mode_reg  <= MODE_IDLE;
            phase_reg <= '0;
            timer_reg <= '0;
            coil_reg  <= '0;
        end else if (s_xfer) begin
            shaft_reg <= shaft_next;
            rem_reg   <= rem_next;
            cw_reg    <= cw_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            coil_reg  <= coil_next;
        end
    end

    // ---------------- output register ----------------
    // Ready whenever the output register is empty or being drained this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_tdata_reg <= {7'd0, arrived_next, (mode_next != MODE_IDLE),
                            shaft_next, coil_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    a_angle_in_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        shaft_reg < TURN)
        else $error("shaft angle outside one turn");

    a_idle_no_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (rem_reg == '0))
        else $error("remaining distance left while idle");

    a_arrived_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[24]) |-> !m_tdata[23])
        else $error("arrived reported while still busy");

    a_xfer_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_tvalid)
        else $error("accepted transfer produced no result");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is stalled");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Stepper positioner check: a directed pass at the reset settings, then
// random command/tick sequences under several step sizes and phase lengths.
// Each accepted command is run through a shaft tracker that predicts the
// readout; readouts are compared field by field in order.

module testbench;
    import sap_pkg::*;

    localparam int unsigned TURN_MDEG = 360000;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;   // codes 5..7 do nothing
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    // Tracks shaft angle, motion and coil drive; holds the readouts still due.
    class shaft_tracker;
        typedef struct packed {
            logic [COIL_W-1:0] coil;
            logic [ANG_W-1:0]  angle;
            logic              busy;
            logic              arrived;
        } readout_t;

        int unsigned step_size;
        int unsigned phase_ticks;
        int unsigned angle;
        int unsigned remaining;
        bit          dir_cw;
        logic [MODE_W-1:0] mode;
        logic [1:0]  phase;
        logic [15:0] timer;
        logic [COIL_W-1:0] coil;
        logic [COIL_W-1:0] cw_seq [4];
        logic [COIL_W-1:0] ccw_seq [4];
        readout_t    readouts_due [$];
        int unsigned faults, commands, readouts, arrivals;

        function new();
            step_size   = STEP_SIZE_RST;
            phase_ticks = PHASE_TICKS_RST;
            angle       = 0;
            remaining   = 0;
            dir_cw      = 0;
            mode        = MODE_IDLE;
            phase       = 0;
            timer       = 0;
            coil        = 0;
            cw_seq      = '{4'h8, 4'h1, 4'h2, 4'h4};
            ccw_seq     = '{4'h1, 4'h8, 4'h4, 4'h2};
            faults      = 0;
            commands    = 0;
            readouts    = 0;
            arrivals    = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_STEP_SIZE)
                step_size = val;
            else
                phase_ticks = val[TICKS_W-1:0];
        endfunction

        function int unsigned pending();
            return readouts_due.size();
        endfunction

        function int unsigned eff_step();
            return (step_size == 0) ? 1 : step_size;
        endfunction

        // Returns 1 when the move is already within two steps (no motion).
        function bit begin_move(int unsigned span, bit cw);
            phase     = 0;
            timer     = 0;
            dir_cw    = cw;
            remaining = span & 32'h7FFFF;
            if (remaining <= 2 * eff_step()) begin
                mode      = MODE_IDLE;
                remaining = 0;
                return 1;
            end
            mode = MODE_POSITION;
            return 0;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [DEG_W-1:0] deg,
                                   logic [JOG_W-1:0] jog);
            readout_t    r;
            int unsigned ticks, target, d, span, s, mdeg;
            bit          arrive;
            arrive = 0;
            mdeg   = deg;
            mdeg   = mdeg * 1000;
            commands++;
            case (op)
                OP_TICK: begin
                    if (mode != MODE_IDLE) begin
                        ticks = (phase_ticks == 0) ? 1 : phase_ticks;
                        if (timer == 0)
                            coil = dir_cw ? cw_seq[phase] : ccw_seq[phase];
                        timer = timer + 16'd1;
                        if (timer >= ticks || timer == 0) begin
                            timer = 0;
                            phase = phase + 2'd1;
                            if (phase == 0) begin
                                s = eff_step() % TURN_MDEG;
                                if (dir_cw)
                                    angle = (angle + s) % TURN_MDEG;
                                else
                                    angle = (angle + TURN_MDEG - s) % TURN_MDEG;
                                if (mode == MODE_POSITION) begin
                                    remaining -= eff_step();
                                    if (remaining <= 2 * eff_step()) begin
                                        mode      = MODE_IDLE;
                                        remaining = 0;
                                        arrive    = 1;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_GOTO: begin
                    target = mdeg % TURN_MDEG;
                    // shorter way round; exactly half a turn goes clockwise
                    if (angle > target) begin
                        d = angle - target;
                        if (d < TURN_MDEG / 2)
                            arrive = begin_move(d, 0);
                        else
                            arrive = begin_move(TURN_MDEG - d, 1);
                    end else begin
                        d = target - angle;
                        if (d > TURN_MDEG / 2)
                            arrive = begin_move(TURN_MDEG - d, 0);
                        else
                            arrive = begin_move(d, 1);
                    end
                end
                OP_ADVANCE: begin
                    span   = mdeg;
                    arrive = begin_move(span, 1);
                end
                OP_ZERO: begin
                    angle     = 0;
                    remaining = 0;
                    mode      = MODE_IDLE;
                    phase     = 0;
                    timer     = 0;
                end
                OP_JOG: begin
                    phase     = 0;
                    timer     = 0;
                    remaining = 0;
                    if (jog == JOG_CW) begin
                        mode   = MODE_JOG;
                        dir_cw = 1;
                    end else if (jog == JOG_CCW) begin
                        mode   = MODE_JOG;
                        dir_cw = 0;
                    end else begin
                        mode = MODE_IDLE;
                    end
                end
                default: begin
                end
            endcase
            r.coil    = coil;
            r.angle   = angle[ANG_W-1:0];
            r.busy    = (mode != MODE_IDLE);
            r.arrived = arrive;
            if (arrive)
                arrivals++;
            readouts_due.push_back(r);
        endfunction

        function void flag(string what);
            faults++;
            if (faults <= 10)
                $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        function void check_readout(logic [31:0] data);
            readout_t want, got;
            got.coil    = data[3:0];
            got.angle   = data[22:4];
            got.busy    = data[23];
            got.arrived = data[24];
            readouts++;
            if (readouts_due.size() == 0) begin
                flag($sformatf("unexpected readout %h", data));
                return;
            end
            want = readouts_due.pop_front();
            if (got.coil !== want.coil)
                flag($sformatf("coil_pattern exp %h got %h", want.coil, got.coil));
            if (got.angle !== want.angle)
                flag($sformatf("current_angle exp %0d got %0d", want.angle, got.angle));
            if (got.busy !== want.busy)
                flag($sformatf("busy exp %b got %b", want.busy, got.busy));
            if (got.arrived !== want.arrived)
                flag($sformatf("arrived exp %b got %b", want.arrived, got.arrived));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;
    logic [OP_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    shaft_tracker tracker = new();
    bit           steady;       // when set, neither side idles
    int           stall_left;

    stepper_angle_positioner_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #20_000_000;
        $display("Timeout: %0d readouts still due", tracker.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: check each result transfer, then pick the next ready level.
    // Mostly ready, short stalls now and then, the odd long one.
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready)
                tracker.check_readout(m_tdata);
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left = stall_left - 1;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DEG_W-1:0] pick_degrees();
        // mostly in range; now and then past a full turn
        if ($urandom_range(0, 99) < 85)
            return DEG_W'($urandom_range(0, 359));
        return DEG_W'($urandom_range(0, 511));
    endfunction

    // One input transfer. Valid stays up across back-to-back commands.
    task automatic send_command(logic [OP_W-1:0] op, logic [DEG_W-1:0] deg,
                                logic [JOG_W-1:0] jog);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, jog, deg};
        do
            @(posedge aclk);
        while (!s_tready);
        tracker.note_command(op, deg, jog);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_command(OP_TICK, DEG_W'($urandom), JOG_W'($urandom));
    endtask

    task automatic drain();
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Register write once the output stream has emptied.
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, val);
    endtask

    // Random part of one setting: a command, then a run of ticks so that
    // moves get far enough to finish; a little noise in between.
    task automatic run_phase(int n_items);
        int sent, r, run;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_command(OP_GOTO, pick_degrees(), JOG_W'($urandom));
            end else if (r < 65) begin
                send_command(OP_ADVANCE, pick_degrees(), JOG_W'($urandom));
            end else if (r < 75) begin
                send_command(OP_JOG, DEG_W'($urandom), JOG_W'($urandom_range(0, 3)));
            end else if (r < 80) begin
                send_command(OP_ZERO, DEG_W'($urandom), JOG_W'($urandom));
            end else if (r < 84) begin
                send_command(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                             DEG_W'($urandom), JOG_W'($urandom));
                sent--;     // ignored codes do not count
            end
            sent++;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 150)
                                              : $urandom_range(0, 40);
            send_ticks(run);
            sent += run;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] step_list  [9];
        logic [CFG_W-1:0] ticks_list [9];
        int               count_list [9];
        bit               calm_list  [9];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_STEP_SIZE;
        cfg_wdata = '0;
        steady    = 1'b0;

        // extremes of both registers, zero values included
        step_list  = '{17'd30000, 17'd30000, 17'd0, 17'd90000, 17'd131071,
                       17'd1, 17'd45000, 17'd12000, 17'd20000};
        ticks_list = '{17'd1, 17'd2, 17'd0, 17'd1, 17'd3,
                       17'd1, 17'd65535, 17'd2, 17'd1};
        count_list = '{300, 200, 80, 200, 150, 60, 40, 300, 320};
        calm_list  = '{0, 1, 0, 0, 0, 0, 0, 1, 0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, at reset settings (step 666, two ticks per pattern).
        send_command(OP_TICK, 9'd0, JOG_STOP);            // tick while idle
        for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
            send_command(OP_W'(k), 9'h1FF, 2'd3);         // ignored codes
        send_command(OP_JOG, 9'd0, JOG_CCW);              // one ccw step: wraps below 0
        send_ticks(8);
        send_command(OP_JOG, 9'd0, JOG_CW);
        send_ticks(2);
        send_command(OP_JOG, 9'd0, 2'd3);                 // direction 3 acts as stop
        send_command(OP_JOG, 9'd0, JOG_STOP);
        send_command(OP_GOTO, 9'd0, JOG_STOP);            // within two steps: arrives at once
        send_command(OP_ZERO, 9'd0, JOG_STOP);
        send_command(OP_GOTO, 9'd180, JOG_STOP);          // exactly half a turn
        send_command(OP_GOTO, 9'd181, JOG_STOP);          // just past half: goes ccw
        send_command(OP_GOTO, 9'd359, JOG_STOP);
        send_command(OP_ADVANCE, 9'd511, JOG_STOP);       // largest advance
        send_command(OP_ADVANCE, 9'd1, JOG_STOP);         // short advance

        for (int p = 0; p < 9; p++) begin
            write_reg(REG_STEP_SIZE, step_list[p]);
            write_reg(REG_PHASE_TICKS, ticks_list[p]);
            steady = calm_list[p];
            run_phase(count_list[p]);
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        drain();
        repeat (4) @(posedge aclk);

        $display("Covered %0d commands, %0d readouts checked, %0d arrivals",
                 tracker.commands, tracker.readouts, tracker.arrivals);
        $display("Settings: reset values plus %0d step size / phase length pairs", 9);
        if (tracker.faults == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d readouts missing", tracker.faults,
                     tracker.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
